[rtl/core/tss_pkg.sv]
// Shared types and constants for the three-stack shared slot store.
package tss_pkg;

    localparam int STACKS        = 3;
    localparam int SLOTS_DEF     = 128;
    localparam int WORD_BITS_DEF = 32;
    localparam int OUT_BITS      = 32;

    typedef logic [1:0] t_stk;

    localparam t_stk STK_0 = 2'd0;
    localparam t_stk STK_1 = 2'd1;
    localparam t_stk STK_2 = 2'd2;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Controller to datapath commands.
    typedef struct packed {
        logic clr_wr;
        logic latch;
        logic push_wr;
        logic pop_rd;
        logic pop_wr;
        logic chk_rd;
        t_stk rd_sel;
        logic chk_ev;
        t_stk ev_sel;
        logic emit;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic clr_last;
        logic sel_ok;
        logic is_pop;
        logic full;
        logic top_vld;
    } t_sts;

endpackage

[rtl/core/tss_ctrl.sv]
// Controller state machine for the three-stack shared slot store.
module tss_ctrl
    import tss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_POP_WR,
        S_CHK0,
        S_CHK1,
        S_CHK2,
        S_CHK3,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_sts.sel_ok) begin
                    n_state = S_DONE;
                end else if (i_sts.is_pop) begin
                    if (i_sts.top_vld) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP_WR;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_sts.full) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.push_wr = 1'b1;
                    n_state       = S_CHK0;
                end
            end
            S_POP_WR: begin
                o_cmd.pop_wr = 1'b1;
                n_state      = S_CHK0;
            end
            // probe top+1 of each stack in order, one read per cycle
            S_CHK0: begin
                o_cmd.chk_rd = 1'b1;
                o_cmd.rd_sel = STK_0;
                n_state      = S_CHK1;
            end
            S_CHK1: begin
                o_cmd.chk_rd = 1'b1;
                o_cmd.rd_sel = STK_1;
                o_cmd.chk_ev = 1'b1;
                o_cmd.ev_sel = STK_0;
                n_state      = S_CHK2;
            end
            S_CHK2: begin
                o_cmd.chk_rd = 1'b1;
                o_cmd.rd_sel = STK_2;
                o_cmd.chk_ev = 1'b1;
                o_cmd.ev_sel = STK_1;
                n_state      = S_CHK3;
            end
            S_CHK3: begin
                o_cmd.chk_ev = 1'b1;
                o_cmd.ev_sel = STK_2;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

[rtl/core/tss_dp.sv]
// Datapath for the three-stack shared slot store: slot memories, stack tops, search.
module tss_dp
    import tss_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_func,
    input  logic [1:0]          i_stack_sel,
    input  logic [31:0]         i_data_in,
    output logic                o_strobe,
    output logic [OUT_BITS-1:0] o_pop_data,
    output logic                o_pop_valid,
    output logic                o_push_done,
    output logic                o_store_full
);

    localparam int IW = $clog2(SLOTS);
    localparam int LW = IW + 1;              // link: valid bit and slot index
    localparam int EW = LW + WORD_BITS;
    localparam logic [IW:0]   SLOTS_W = (IW + 1)'(SLOTS);
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    logic          used_mem [SLOTS];
    logic [EW-1:0] slot_mem [SLOTS];

    logic                r_func;
    t_stk                r_sel;
    logic [31:0]         r_data;
    logic                r_top_vld [STACKS];
    logic [IW-1:0]       r_top_idx [STACKS];
    logic [IW-1:0]       r_next_free;
    logic                r_full;
    logic                r_found;
    logic                r_rec;
    logic                r_used_rd;
    logic [EW-1:0]       r_slot_rd;
    logic [IW-1:0]       r_clr_cnt;
    logic [OUT_BITS-1:0] r_pop_word;
    logic                r_pop_valid;
    logic                r_push_done;
    logic                r_out_strobe;
    logic [OUT_BITS-1:0] r_out_pop_data;
    logic                r_out_pop_valid;
    logic                r_out_push_done;
    logic                r_out_full;

    logic [IW:0]    cand     [STACKS];
    logic           cand_in  [STACKS];
    logic [IW-1:0]  top_idx_sel;
    logic           top_vld_sel;
    logic           sel_ok;
    logic           u_we;
    logic [IW-1:0]  u_addr;
    logic           u_din;
    logic [EW-1:0]  slot_din;
    logic           rd_link_vld;
    logic [IW-1:0]  rd_link_idx;
    logic [WORD_BITS-1:0] rd_word;
    logic           full_new;

    always_comb begin
        for (int s = 0; s < STACKS; s++) begin
            cand[s]    = r_top_vld[s] ? ({1'b0, r_top_idx[s]} + 1'b1) : '0;
            cand_in[s] = (cand[s] < SLOTS_W);
        end
    end

    assign sel_ok      = (r_sel != t_stk'(STACKS));
    assign top_idx_sel = r_top_idx[r_sel];
    assign top_vld_sel = sel_ok && r_top_vld[r_sel];

    assign o_sts.clr_last = (r_clr_cnt == LAST_SLOT);
    assign o_sts.sel_ok   = sel_ok;
    assign o_sts.is_pop   = (r_func == FUNC_POP);
    assign o_sts.full     = r_full;
    assign o_sts.top_vld  = top_vld_sel;

    // one write port on the used bits: clear pass, push mark, pop release
    always_comb begin
        u_we   = i_cmd.clr_wr | i_cmd.push_wr | i_cmd.pop_wr;
        u_din  = i_cmd.push_wr;
        if (i_cmd.clr_wr) begin
            u_addr = r_clr_cnt;
        end else if (i_cmd.push_wr) begin
            u_addr = r_next_free;
        end else begin
            u_addr = top_idx_sel;
        end
    end

    assign slot_din    = {top_vld_sel, top_idx_sel, WORD_BITS'(r_data)};
    assign rd_link_vld = r_slot_rd[EW-1];
    assign rd_link_idx = r_slot_rd[EW-2:WORD_BITS];
    assign rd_word     = r_slot_rd[WORD_BITS-1:0];
    assign full_new    = r_rec ? !r_found : r_full;

    always_ff @(posedge i_clk) begin
        if (u_we) begin
            used_mem[u_addr] <= u_din;
        end
        if (i_cmd.chk_rd) begin
            r_used_rd <= used_mem[cand[i_cmd.rd_sel][IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            slot_mem[r_next_free] <= slot_din;
        end
        if (i_cmd.pop_rd) begin
            r_slot_rd <= slot_mem[top_idx_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func <= i_func;
            r_sel  <= i_stack_sel;
            r_data <= i_data_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STACKS; s++) begin
                r_top_vld[s] <= 1'b0;
                r_top_idx[s] <= '0;
            end
            r_next_free  <= '0;
            r_full       <= 1'b0;
            r_found      <= 1'b0;
            r_rec        <= 1'b0;
            r_clr_cnt    <= '0;
            r_pop_valid  <= 1'b0;
            r_push_done  <= 1'b0;
            r_pop_word   <= '0;
            r_out_strobe <= 1'b0;
        end else begin
            r_out_strobe <= i_cmd.emit;
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.latch) begin
                r_found     <= 1'b0;
                r_rec       <= 1'b0;
                r_pop_valid <= 1'b0;
                r_push_done <= 1'b0;
                r_pop_word  <= '0;
            end
            if (i_cmd.push_wr) begin
                r_top_vld[r_sel] <= 1'b1;
                r_top_idx[r_sel] <= r_next_free;
                r_push_done      <= 1'b1;
                r_rec            <= 1'b1;
            end
            if (i_cmd.pop_wr) begin
                r_top_vld[r_sel] <= rd_link_vld;
                r_top_idx[r_sel] <= rd_link_idx;
                r_pop_word       <= OUT_BITS'(rd_word);
                r_pop_valid      <= 1'b1;
                r_rec            <= 1'b1;
            end
            // first free candidate in stack order wins
            if (i_cmd.chk_ev && !r_found && cand_in[i_cmd.ev_sel] && !r_used_rd) begin
                r_found     <= 1'b1;
                r_next_free <= cand[i_cmd.ev_sel][IW-1:0];
            end
            if (i_cmd.emit) begin
                r_full <= full_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_pop_data  <= r_pop_word;
            r_out_pop_valid <= r_pop_valid;
            r_out_push_done <= r_push_done;
            r_out_full      <= full_new;
        end
    end

    assign o_strobe     = r_out_strobe;
    assign o_pop_data   = r_out_pop_data;
    assign o_pop_valid  = r_out_pop_valid;
    assign o_push_done  = r_out_push_done;
    assign o_store_full = r_out_full;

endmodule

[rtl/core/three_stacks_shared_store_unit.sv]
// Three stacks sharing one slot store: top level with controller and datapath.
//
// Each transaction (push or pop on stack 0..2) is taken when start is high and busy is
// low, and gives exactly one result on the o_ ports, marked by o_strobe for one cycle,
// in the same cycle as busy falls; the receiver cannot stall it. A transaction that
// changes nothing (stack 3, push while full, pop of an empty stack) goes straight to
// the result; a push and a pop take longer, since the single read port of the used-bit
// memory probes the slot above each of the three stack tops one after another, and a
// pop adds one memory read for the popped word. After reset the block runs a clearing
// pass over every used bit, with busy high.
module three_stacks_shared_store_unit
    import tss_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_func,
    input  logic [1:0]          i_stack_sel,
    input  logic [31:0]         i_data_in,
    output logic                o_strobe,
    output logic [OUT_BITS-1:0] o_pop_data,
    output logic                o_pop_valid,
    output logic                o_push_done,
    output logic                o_store_full
);

    t_cmd cmd;
    t_sts sts;

    tss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tss_dp #(
        .SLOTS     (SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_func       (i_func),
        .i_stack_sel  (i_stack_sel),
        .i_data_in    (i_data_in),
        .o_strobe     (o_strobe),
        .o_pop_data   (o_pop_data),
        .o_pop_valid  (o_pop_valid),
        .o_push_done  (o_push_done),
        .o_store_full (o_store_full)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_pop_valid && o_push_done))
        else $error("result claims both a pop and a push");

    a_pop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_pop_valid) |-> (o_pop_data == '0))
        else $error("pop data nonzero without a popped word");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    a_no_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy || $past(start))
        else $error("result strobe while a transaction is still in progress");

endmodule
